@@ sv/rc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pkg: shared definitions for the radix converter
// Constants, sequencer states and character helpers used by the converter.
// ----------------------------------------------------------------------------
package rc_pkg;

  localparam int VALUE_BITS_DEF = 31;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_F = 8'h46;
  localparam logic [3:0] DEC_TEN     = 4'd10;

  localparam logic [4:0] BASE_MIN = 5'd2;
  localparam logic [4:0] BASE_MAX = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_WGT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       bad;
  } digit_dec_t;

  function automatic digit_dec_t char_to_digit(input logic [7:0] ch);
    digit_dec_t r;
    r.digit = 4'd0;
    r.bad   = 1'b0;
    if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
      r.digit = 4'(ch - ASCII_ZERO);
    end else if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_F) begin
      r.digit = 4'(ch - ASCII_UPPER_A) + DEC_TEN;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [6:0] digit_to_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < DEC_TEN) begin
      c = {3'b000, d} + ASCII_ZERO[6:0];
    end else begin
      c = {3'b000, d - DEC_TEN} + ASCII_UPPER_A[6:0];
    end
    return c;
  endfunction

  function automatic logic [4:0] clamp_base(input logic [4:0] b);
    logic [4:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

@@ sv/rc_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_scale: multiply-add unit with overflow detection
// Computes weight * factor + addend and reports when the result exceeds the
// value range. Shared by the digit accumulation and the weight update.
// ----------------------------------------------------------------------------
module rc_scale import rc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS:0]   weight,
  input  logic [4:0]            factor,
  input  logic [VALUE_BITS-1:0] addend,
  output logic [VALUE_BITS-1:0] result,
  output logic                  over
);

  localparam int PW = VALUE_BITS + 6;

  logic [PW-1:0] prod;
  logic [PW-1:0] sum;

  always_comb begin
    prod   = PW'(weight) * PW'(factor);
    sum    = prod + PW'(addend);
    over   = |sum[PW-1:VALUE_BITS];
    result = sum[VALUE_BITS-1:0];
  end

endmodule

@@ sv/rc_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_divider: iterative restoring divider
// Divides a value by a small base, one quotient bit per cycle, and pulses
// done when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module rc_divider import rc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [4:0]            divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [3:0]            remainder
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] quot_r, quot_nxt;
  logic [3:0]            rem_r, rem_nxt;
  logic [4:0]            shifted;
  logic                  fits;

  always_comb begin
    shifted  = {rem_r, quot_r[VALUE_BITS-1]};
    fits     = (shifted >= divisor);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VALUE_BITS);
      quot_nxt = dividend;
      rem_nxt  = 4'd0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[VALUE_BITS-2:0], fits};
      rem_nxt  = fits ? 4'(shifted - divisor) : shifted[3:0];
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quot_r;
  assign remainder = rem_r;

endmodule

@@ sv/radix_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_converter: ASCII number radix converter
// Accumulates ASCII digits in a source base, least significant first, and
// emits the value in a target base as ASCII digits by repeated division.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  in_*      in_valid/in_ready   digit_char, source_base, target_base, last_in
//  out_*     out_valid/out_ready out_char, last_out, bad_digit, overflow
//
//  An item that is not last passes through accept, accumulate and weight update,
//  the last two steps saturating through one shared multiply-add unit.
//  A last item then yields its digits one at a time from the bit-serial
//  divider, each one held until out_ready.
//  The block takes no item while an item is being accumulated or a number emitted.
//  Reset is synchronous and leaves the block idle with an empty accumulator.
// ----------------------------------------------------------------------------
module radix_converter import rc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_digit_char,
  input  logic [4:0] in_source_base,
  input  logic [4:0] in_target_base,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last_out,
  output logic       out_bad_digit,
  output logic       out_overflow
);

  localparam logic [VALUE_BITS-1:0] MAX_VALUE  = '1;
  localparam logic [VALUE_BITS:0]   WEIGHT_ONE = (VALUE_BITS+1)'(1);
  localparam logic [VALUE_BITS:0]   WEIGHT_SAT = {1'b1, {VALUE_BITS{1'b0}}};

  state_t                state_r, state_nxt;
  logic [3:0]            digit_r, digit_nxt;
  logic [4:0]            sbase_r, sbase_nxt;
  logic [4:0]            tbase_r, tbase_nxt;
  logic                  last_r, last_nxt;
  logic [VALUE_BITS-1:0] accum_r, accum_nxt;
  logic [VALUE_BITS:0]   weight_r, weight_nxt;
  logic                  bad_r, bad_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  emit_r, emit_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [6:0]            char_r, char_nxt;
  logic                  lout_r, lout_nxt;

  digit_dec_t            dec;
  logic [4:0]            u_factor;
  logic [VALUE_BITS-1:0] u_addend;
  logic [VALUE_BITS-1:0] u_result;
  logic                  u_over;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [3:0]            div_rem;

  rc_scale #(.VALUE_BITS(VALUE_BITS)) u_scale (
    .weight (weight_r),
    .factor (u_factor),
    .addend (u_addend),
    .result (u_result),
    .over   (u_over)
  );

  rc_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (tbase_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt    = state_r;
    digit_nxt    = digit_r;
    sbase_nxt    = sbase_r;
    tbase_nxt    = tbase_r;
    last_nxt     = last_r;
    accum_nxt    = accum_r;
    weight_nxt   = weight_r;
    bad_nxt      = bad_r;
    ovf_nxt      = ovf_r;
    emit_nxt     = emit_r;
    val_nxt      = val_r;
    char_nxt     = char_r;
    lout_nxt     = lout_r;
    dec          = char_to_digit(in_digit_char);
    u_factor     = {1'b0, digit_r};
    u_addend     = accum_r;
    div_start    = 1'b0;
    div_dividend = val_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid) begin
          digit_nxt = dec.digit;
          sbase_nxt = clamp_base(in_source_base);
          tbase_nxt = clamp_base(in_target_base);
          last_nxt  = in_last_in;
          if (emit_r) begin
            accum_nxt  = '0;
            weight_nxt = WEIGHT_ONE;
            ovf_nxt    = 1'b0;
            emit_nxt   = 1'b0;
            bad_nxt    = dec.bad;
          end else begin
            bad_nxt = bad_r | dec.bad;
          end
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (digit_r != 4'd0) begin
          if (u_over) begin
            accum_nxt = MAX_VALUE;
            ovf_nxt   = 1'b1;
          end else begin
            accum_nxt = u_result;
          end
        end
        state_nxt = ST_WGT;
      end
      ST_WGT: begin
        u_factor   = sbase_r;
        u_addend   = '0;
        weight_nxt = u_over ? WEIGHT_SAT : {1'b0, u_result};
        if (last_r) begin
          emit_nxt     = 1'b1;
          div_start    = 1'b1;
          div_dividend = accum_r;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          char_nxt  = digit_to_char(div_rem);
          lout_nxt  = (div_quot == '0);
          val_nxt   = div_quot;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (lout_r) begin
            state_nxt = ST_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      accum_r  <= '0;
      weight_r <= WEIGHT_ONE;
      bad_r    <= 1'b0;
      ovf_r    <= 1'b0;
      emit_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      accum_r  <= accum_nxt;
      weight_r <= weight_nxt;
      bad_r    <= bad_nxt;
      ovf_r    <= ovf_nxt;
      emit_r   <= emit_nxt;
    end
    digit_r <= digit_nxt;
    sbase_r <= sbase_nxt;
    tbase_r <= tbase_nxt;
    last_r  <= last_nxt;
    val_r   <= val_nxt;
    char_r  <= char_nxt;
    lout_r  <= lout_nxt;
  end

  assign out_char      = char_r;
  assign out_last_out  = lout_r;
  assign out_bad_digit = bad_r;
  assign out_overflow  = ovf_r;

endmodule

@@ sv/rc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_checker: port-level checks for the radix converter
// Watches the handshakes and result digits of the converter at its ports.
// ----------------------------------------------------------------------------
module rc_checker import rc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       out_last_out,
  input logic       out_bad_digit,
  input logic       out_overflow
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(out_last_out) && $stable(out_bad_digit) && $stable(out_overflow))
    else $error("result item changed while stalled");

  // Input is never taken while a result item is offered.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // Every emitted character is a legal digit.
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= ASCII_ZERO[6:0] && out_char <= ASCII_NINE[6:0]) ||
      (out_char >= ASCII_UPPER_A[6:0] && out_char <= ASCII_UPPER_F[6:0]))
    else $error("illegal output character");

  // After a digit that is not the final one, more digits follow before input.
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_out |=> !in_ready)
    else $error("input ready before the final digit");

  // An accepted input item keeps the block busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

endmodule

bind radix_converter rc_checker u_rc_checker (.*);

@@ sim/radix_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_converter_tb: self-checking testbench for the radix converter
// Feeds ASCII digit items, least significant first, in directed and random
// numbers with random idle cycles on both channels. A scoreboard predicts the
// digits of each converted number and checks every emitted item in order.
// ----------------------------------------------------------------------------
module radix_converter_tb;
  import rc_pkg::*;

  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS_DEF) - 64'd1;
  localparam int NUM_ITEMS = 360;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = VALUE_BITS_DEF + 10;

  typedef struct {
    logic [6:0] ch;
    logic       is_last;
    logic       bad;
    logic       ovf;
  } out_digit_t;

  class radix_scoreboard;
    longint unsigned accum;
    longint unsigned weight;
    bit              bad_seen;
    bit              ovf_seen;
    bit              finished;
    out_digit_t      due_digits[$];
    int              error_count;

    function new();
      error_count = 0;
      restart();
    endfunction

    function void restart();
      accum    = 0;
      weight   = 1;
      bad_seen = 1'b0;
      ovf_seen = 1'b0;
      finished = 1'b0;
    endfunction

    function longint unsigned base_of(logic [4:0] b);
      if (b < BASE_MIN) begin
        return BASE_MIN;
      end
      if (b > BASE_MAX) begin
        return BASE_MAX;
      end
      return b;
    endfunction

    function void take_digit(logic [7:0] ch, logic [4:0] src, logic [4:0] dst,
                             logic is_last);
      longint unsigned dig;
      longint unsigned val;
      longint unsigned rem;
      longint unsigned sbase;
      longint unsigned tbase;
      out_digit_t      want;
      if (finished) begin
        restart();
      end
      sbase = base_of(src);
      tbase = base_of(dst);
      if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
        dig = ch - ASCII_ZERO;
      end else if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_F) begin
        dig = ch - ASCII_UPPER_A + DEC_TEN;
      end else begin
        dig = 0;
        bad_seen = 1'b1;
      end
      if (dig != 0) begin
        if (weight > (VALUE_MAX - accum) / dig) begin
          accum = VALUE_MAX;
          ovf_seen = 1'b1;
        end else begin
          accum = accum + weight * dig;
        end
      end
      if (weight > VALUE_MAX / sbase) begin
        weight = VALUE_MAX + 1;
      end else begin
        weight = weight * sbase;
      end
      if (!is_last) begin
        return;
      end
      finished = 1'b1;
      val = accum;
      do begin
        rem = val % tbase;
        if (rem < DEC_TEN) begin
          want.ch = 7'(rem + ASCII_ZERO);
        end else begin
          want.ch = 7'(rem - DEC_TEN + ASCII_UPPER_A);
        end
        val = val / tbase;
        want.is_last = (val == 0);
        want.bad = bad_seen;
        want.ovf = ovf_seen;
        due_digits.push_back(want);
      end while (val != 0);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_digit(logic [6:0] ch, logic is_last, logic bad, logic ovf);
      out_digit_t want;
      if (due_digits.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual char %h", $time, ch);
        error_count++;
        return;
      end
      want = due_digits.pop_front();
      compare_field("out_char", want.ch, ch);
      compare_field("out_last_out", want.is_last, is_last);
      compare_field("out_bad_digit", want.bad, bad);
      compare_field("out_overflow", want.ovf, ovf);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_digit_char = 8'd0;
  logic [4:0] in_source_base = 5'd0;
  logic [4:0] in_target_base = 5'd0;
  logic       in_last_in = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       out_last_out;
  logic       out_bad_digit;
  logic       out_overflow;

  radix_scoreboard scb;
  int              items_sent = 0;
  int              idle_cycles = 0;
  bit              in_steady = 1'b0;
  bit              out_steady = 1'b0;

  always #6 clk = ~clk;

  radix_converter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_digit_char  (in_digit_char),
    .in_source_base (in_source_base),
    .in_target_base (in_target_base),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last_out   (out_last_out),
    .out_bad_digit  (out_bad_digit),
    .out_overflow   (out_overflow)
  );

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) begin
      return ASCII_ZERO + 8'(v);
    end
    return ASCII_UPPER_A + 8'(v - 10);
  endfunction

  task automatic send_item(logic [7:0] ch, logic [4:0] src, logic [4:0] dst,
                           logic is_last);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_digit_char  <= ch;
    in_source_base <= src;
    in_target_base <= dst;
    in_last_in     <= is_last;
    do @(posedge clk); while (!in_ready);
    scb.take_digit(ch, src, dst, is_last);
    items_sent++;
  endtask

  task automatic send_run(logic [7:0] ch, int count, logic [4:0] src, logic [4:0] dst,
                          logic is_last);
    for (int k = 0; k < count; k++) begin
      send_item(ch, src, dst, is_last && (k == count - 1));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        out_steady = !out_steady;
      end
      stall = out_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      scb.check_digit(out_char, out_last_out, out_bad_digit, out_overflow);
    end
  end

  initial begin
    int         len;
    int         pick;
    int         src_lim;
    logic [4:0] src;
    logic [4:0] item_src;
    logic [4:0] dst;
    logic [7:0] ch;
    scb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A zero value gives a single zero digit.
    send_item(ASCII_ZERO, 5'd10, 5'd10, 1'b1);
    // Invalid characters at both ends of the byte range, bases out of range.
    send_item(8'hFF, 5'd31, 5'd16, 1'b0);
    send_item(8'h00, 5'd17, 5'd2, 1'b0);
    send_item(ASCII_NINE, 5'd0, 5'd1, 1'b1);
    // Digits at or above the source base are taken with their plain value.
    send_item(ASCII_UPPER_F, 5'd10, 5'd17, 1'b0);
    send_item(ASCII_UPPER_A, 5'd1, 5'd31, 1'b1);
    // Characters just outside the digit ranges.
    send_item(ASCII_ZERO - 8'd1, 5'd16, 5'd16, 1'b0);
    send_item(ASCII_NINE + 8'd1, 5'd16, 5'd16, 1'b0);
    send_item(ASCII_UPPER_A - 8'd1, 5'd16, 5'd16, 1'b0);
    send_item(ASCII_UPPER_F + 8'd1, 5'd16, 5'd3, 1'b1);
    // Largest value without saturation, emitted in binary.
    send_run(ASCII_UPPER_F, 7, 5'd16, 5'd2, 1'b0);
    send_item(ASCII_ZERO + 8'd7, 5'd16, 5'd2, 1'b1);
    // Saturation.
    send_run(ASCII_UPPER_F, 8, 5'd16, 5'd16, 1'b1);

    while (items_sent < NUM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        in_steady = !in_steady;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 34) : $urandom_range(1, 8);
      src = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                                          5'($urandom_range(2, 16));
      src_lim = (src < BASE_MIN) ? int'(BASE_MIN) :
                (src > BASE_MAX) ? int'(BASE_MAX) : int'(src);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          ch = 8'($urandom_range(0, 255));
        end else if (pick == 1) begin
          ch = hex_char($urandom_range(0, 15));
        end else begin
          ch = hex_char($urandom_range(0, src_lim - 1));
        end
        item_src = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31)) : src;
        dst = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                                            5'($urandom_range(2, 16));
        send_item(ch, item_src, dst, k == len - 1);
      end
    end

    in_valid <= 1'b0;
    while (scb.due_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scb.error_count == 0 && scb.due_digits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
